/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/core/ceus_pkg.sv */
// Package for the escape decoder: character codes, mode and register types,
// and the small decode functions. No dependencies.
package ceus_pkg;

    localparam int LENGTH_WIDTH_DEF = 16;
    localparam int OUTQ_DEPTH       = 4;     // result queue, power of two, >= 2
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH   = 8;

    // characters
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_7         = 8'h37;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LB        = 8'h62;
    localparam logic [7:0] CH_LF        = 8'h66;
    localparam logic [7:0] CH_LN        = 8'h6E;
    localparam logic [7:0] CH_LR        = 8'h72;
    localparam logic [7:0] CH_LT        = 8'h74;
    localparam logic [7:0] CH_LV        = 8'h76;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;

    // control codes
    localparam logic [7:0] CC_BEL = 8'h07;
    localparam logic [7:0] CC_BS  = 8'h08;
    localparam logic [7:0] CC_FF  = 8'h0C;
    localparam logic [7:0] CC_LF  = 8'h0A;
    localparam logic [7:0] CC_CR  = 8'h0D;
    localparam logic [7:0] CC_HT  = 8'h09;
    localparam logic [7:0] CC_VT  = 8'h0B;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_DBCS_ENABLE   = 3'd0,
        CFG_LEAD_ONE_LOW  = 3'd1,
        CFG_LEAD_ONE_HIGH = 3'd2,
        CFG_LEAD_TWO_LOW  = 3'd3,
        CFG_LEAD_TWO_HIGH = 3'd4
    } cfg_index_t;

    typedef enum logic [4:0] {
        M_PLAIN = 5'b00001,
        M_ESC   = 5'b00010,
        M_HEX   = 5'b00100,
        M_OCT   = 5'b01000,
        M_TRAIL = 5'b10000
    } mode_t;

    typedef struct packed {
        logic       dbcs_enable;
        logic [7:0] lead_one_low;
        logic [7:0] lead_one_high;
        logic [7:0] lead_two_low;
        logic [7:0] lead_two_high;
    } lead_cfg_t;

    // results of one decode step: up to two, slot 0 first
    typedef struct packed {
        logic [1:0] n_res;
        logic [7:0] dat0;
        logic       end0;
        logic [7:0] dat1;
        logic       end1;
    } step_res_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } esc_map_t;

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t h;
        h.hit = 1'b1;
        if (b >= CH_0 && b <= CH_9)
            h.val = b[3:0];
        else if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF))
            h.val = 4'(b[3:0] + 4'd9);
        else
        begin
            h.hit = 1'b0;
            h.val = 4'd0;
        end
        return h;
    endfunction

    function automatic esc_map_t esc_code(input logic [7:0] b);
        esc_map_t e;
        e.hit = 1'b1;
        case (b)
            CH_LA:   e.code = CC_BEL;
            CH_LB:   e.code = CC_BS;
            CH_LF:   e.code = CC_FF;
            CH_LN:   e.code = CC_LF;
            CH_LR:   e.code = CC_CR;
            CH_LT:   e.code = CC_HT;
            CH_LV:   e.code = CC_VT;
            default:
            begin
                e.hit  = 1'b0;
                e.code = CH_NUL;
            end
        endcase
        return e;
    endfunction

    function automatic logic is_lead(input logic [7:0] b, input lead_cfg_t c);
        return c.dbcs_enable && b[7] &&
               ((b >= c.lead_one_low && b <= c.lead_one_high) ||
                (b >= c.lead_two_low && b <= c.lead_two_high));
    endfunction

endpackage

/* rtl/core/ceus_decode.sv */
// Decode step of the escape decoder: mode, digit and length state, and the
// logic that turns one byte into zero, one or two results. Uses ceus_pkg.
module ceus_decode #(
    parameter int LENGTH_WIDTH = ceus_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step_go,
    input  logic [7:0]              byte_in,
    input  ceus_pkg::lead_cfg_t     lead_cfg,
    output ceus_pkg::step_res_t     res,
    output logic [LENGTH_WIDTH-1:0] end_length
);
    import ceus_pkg::*;

    localparam logic [LENGTH_WIDTH+1:0] LEN_MAX = {2'b00, {LENGTH_WIDTH{1'b1}}};

    mode_t                   mode_reg, mode_next;
    logic [7:0]              digit_reg, digit_next;
    logic [LENGTH_WIDTH-1:0] count_reg, count_next;

    hex_t                    hx;
    esc_map_t                em;
    logic                    oct_dig;
    logic                    lead;
    logic                    is_nul;
    logic [1:0]              n_data;
    logic                    do_end;
    logic [LENGTH_WIDTH+1:0] count_sum;
    logic [LENGTH_WIDTH-1:0] count_sat;

    assign hx      = hex_digit(byte_in);
    assign em      = esc_code(byte_in);
    assign oct_dig = (byte_in >= CH_0) && (byte_in <= CH_7);
    assign lead    = is_lead(byte_in, lead_cfg);
    assign is_nul  = (byte_in == CH_NUL);

    always_comb
    begin
        mode_next  = mode_reg;
        digit_next = digit_reg;
        res        = '0;
        n_data     = 2'd0;
        do_end     = 1'b0;
        unique case (mode_reg)
            M_ESC:
            begin
                mode_next = M_PLAIN;
                if (em.hit)
                begin
                    res.n_res = 2'd1;
                    res.dat0  = em.code;
                    n_data    = 2'd1;
                end
                else if (byte_in == CH_X)
                begin
                    mode_next  = M_HEX;
                    digit_next = 8'd0;
                end
                else if (oct_dig)
                begin
                    mode_next  = M_OCT;
                    digit_next = {5'd0, byte_in[2:0]};
                end
                else if (is_nul)
                begin
                    res.n_res = 2'd1;
                    res.end0  = 1'b1;
                    do_end    = 1'b1;
                end
                else
                begin
                    res.n_res = 2'd1;
                    res.dat0  = byte_in;
                    n_data    = 2'd1;
                    mode_next = lead ? M_TRAIL : M_PLAIN;
                end
            end
            M_HEX, M_OCT:
            begin
                if (mode_reg == M_HEX && hx.hit)
                    digit_next = {digit_reg[3:0], hx.val};
                else if (mode_reg == M_OCT && oct_dig)
                    digit_next = {digit_reg[4:0], byte_in[2:0]};
                else
                begin
                    // run ended: emit the value, then treat this byte afresh
                    res.n_res  = 2'd1;
                    res.dat0   = digit_reg;
                    n_data     = 2'd1;
                    digit_next = 8'd0;
                    mode_next  = M_PLAIN;
                    if (byte_in == CH_BACKSLASH)
                        mode_next = M_ESC;
                    else if (is_nul)
                    begin
                        res.n_res = 2'd2;
                        res.end1  = 1'b1;
                        do_end    = 1'b1;
                    end
                    else
                    begin
                        res.n_res = 2'd2;
                        res.dat1  = byte_in;
                        n_data    = 2'd2;
                        mode_next = lead ? M_TRAIL : M_PLAIN;
                    end
                end
            end
            M_TRAIL:
            begin
                res.n_res = 2'd1;
                mode_next = M_PLAIN;
                if (is_nul)
                begin
                    res.end0 = 1'b1;
                    do_end   = 1'b1;
                end
                else
                begin
                    res.dat0 = byte_in;
                    n_data   = 2'd1;
                end
            end
            M_PLAIN:
            begin
                if (byte_in == CH_BACKSLASH)
                    mode_next = M_ESC;
                else if (is_nul)
                begin
                    res.n_res = 2'd1;
                    res.end0  = 1'b1;
                    do_end    = 1'b1;
                end
                else
                begin
                    res.n_res = 2'd1;
                    res.dat0  = byte_in;
                    n_data    = 2'd1;
                    mode_next = lead ? M_TRAIL : M_PLAIN;
                end
            end
            default:
                mode_next = M_PLAIN;
        endcase
        if (do_end)
        begin
            mode_next  = M_PLAIN;
            digit_next = 8'd0;
        end
    end

    // data bytes of this step count before a terminator of the same step
    assign count_sum  = {2'b00, count_reg} + {{LENGTH_WIDTH{1'b0}}, n_data};
    assign count_sat  = (count_sum > LEN_MAX) ? {LENGTH_WIDTH{1'b1}}
                                              : count_sum[LENGTH_WIDTH-1:0];
    assign end_length = count_sat;
    assign count_next = do_end ? '0 : count_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_PLAIN;
            digit_reg <= 8'd0;
            count_reg <= '0;
        end
        else if (step_go)
        begin
            mode_reg  <= mode_next;
            digit_reg <= digit_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/core/ceus_outq.sv */
// Result queue of the escape decoder: takes up to two entries per cycle,
// hands out one per cycle. Uses ceus_pkg for nothing but the default depth.
module ceus_outq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ceus_pkg::OUTQ_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       wr_cnt,
    input  logic [WIDTH-1:0] wr_data0,
    input  logic [WIDTH-1:0] wr_data1,
    input  logic             rd_pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data,
    output logic             room_two
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [PW-1:0]    wr_ptr_inc;

    assign wr_ptr_inc  = wr_ptr_reg + PW'(1);
    assign wr_ptr_next = wr_ptr_reg + PW'(wr_cnt);
    assign rd_ptr_next = rd_ptr_reg + PW'(rd_pop);
    assign count_next  = count_reg + CW'(wr_cnt) - CW'(rd_pop);

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign room_two = (count_reg <= CW'(DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= wr_data0;
        if (wr_cnt == 2'd2)
            mem_reg[wr_ptr_inc] <= wr_data1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/c_escape_unslash_stream_top.sv */
// Top level of the C escape sequence decoder: config registers, input
// register, decode step and result queue. Uses ceus_pkg, ceus_decode, ceus_outq.
//
//   channel | handshake                  | payload
//   --------+----------------------------+----------------------------------
//   in      | in_valid / in_stall        | in_byte
//   out     | out_valid / out_stall      | out_byte, run_last, string_end,
//           |                            | decoded_length
//   cfg     | cfg_wr_en (no wait)        | cfg_index, cfg_wdata
//
// One request per cycle in and out while neither side stalls. An accepted
// request is held in the input register until the queue has room for two
// results, then decoded into the result queue, which drives out_valid.
// A request that ends a hex or octal run with a byte other than a backslash
// produces two results, which leave the queue in order.
// The input register holds its request while the queue has fewer than two
// free entries, so in_stall comes only from output back-pressure.
// rst_n clears the decode state and the queue and sets the config registers to their defaults.
module c_escape_unslash_stream_top #(
    parameter int LENGTH_WIDTH = ceus_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [ceus_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [ceus_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           in_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [7:0]                           out_byte,
    output logic                                 run_last,
    output logic                                 string_end,
    output logic [LENGTH_WIDTH-1:0]              decoded_length
);
    import ceus_pkg::*;

    // queue entry: {byte, run_last, string_end, length}
    localparam int QW = 8 + 2 + LENGTH_WIDTH;

    lead_cfg_t               cfg_reg;
    logic                    in_vld_reg;
    logic [7:0]              in_byte_reg;
    logic                    take;
    logic                    step_go;
    logic                    room_two;
    step_res_t               res;
    logic [LENGTH_WIDTH-1:0] end_length;
    logic [1:0]              wr_cnt;
    logic [QW-1:0]           wr_data0;
    logic [QW-1:0]           wr_data1;
    logic [QW-1:0]           rd_data;
    logic                    pop;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dbcs_enable   <= 1'b0;
            cfg_reg.lead_one_low  <= 8'd129;
            cfg_reg.lead_one_high <= 8'd159;
            cfg_reg.lead_two_low  <= 8'd224;
            cfg_reg.lead_two_high <= 8'd252;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DBCS_ENABLE:   cfg_reg.dbcs_enable   <= cfg_wdata[0];
                CFG_LEAD_ONE_LOW:  cfg_reg.lead_one_low  <= cfg_wdata;
                CFG_LEAD_ONE_HIGH: cfg_reg.lead_one_high <= cfg_wdata;
                CFG_LEAD_TWO_LOW:  cfg_reg.lead_two_low  <= cfg_wdata;
                CFG_LEAD_TWO_HIGH: cfg_reg.lead_two_high <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // input register: decoded as soon as the queue can take two results
    assign step_go  = in_vld_reg && room_two;
    assign in_stall = in_vld_reg && !room_two;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (take)
            in_vld_reg <= 1'b1;
        else if (step_go)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_byte_reg <= in_byte;
    end

    ceus_decode #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_go    (step_go),
        .byte_in    (in_byte_reg),
        .lead_cfg   (cfg_reg),
        .res        (res),
        .end_length (end_length)
    );

    // run_last marks the final result of a request; length only with the NUL
    assign wr_cnt   = step_go ? res.n_res : 2'd0;
    assign wr_data0 = {res.dat0, (res.n_res == 2'd1), res.end0,
                       (res.end0 ? end_length : {LENGTH_WIDTH{1'b0}})};
    assign wr_data1 = {res.dat1, 1'b1, res.end1,
                       (res.end1 ? end_length : {LENGTH_WIDTH{1'b0}})};

    assign pop = out_valid && !out_stall;

    ceus_outq #(
        .WIDTH (QW),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cnt   (wr_cnt),
        .wr_data0 (wr_data0),
        .wr_data1 (wr_data1),
        .rd_pop   (pop),
        .rd_valid (out_valid),
        .rd_data  (rd_data),
        .room_two (room_two)
    );

    assign out_byte       = rd_data[QW-1 -: 8];
    assign run_last       = rd_data[LENGTH_WIDTH+1];
    assign string_end     = rd_data[LENGTH_WIDTH];
    assign decoded_length = rd_data[LENGTH_WIDTH-1:0];

endmodule

/* rtl/core/ceus_chk.sv */
// Port checker for the escape decoder top level, attached by bind.
// Uses assert_macros.svh and ceus_pkg.
`include "assert_macros.svh"

module ceus_chk #(
    parameter int LENGTH_WIDTH = ceus_pkg::LENGTH_WIDTH_DEF
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_wr_en,
    input logic [ceus_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input logic [ceus_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic [7:0]                           in_byte,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [7:0]                           out_byte,
    input logic                                 run_last,
    input logic                                 string_end,
    input logic [LENGTH_WIDTH-1:0]              decoded_length
);
    import ceus_pkg::*;

    // terminator is a NUL and always the last result of its request
    `ASSERT_CLK(a_end_is_last, out_valid && string_end |-> out_byte == CH_NUL && run_last, "terminator result malformed")

    // length is shown only with the terminator
    `ASSERT_CLK(a_len_zero, out_valid && !string_end |-> decoded_length == '0, "length on a data result")

    // input stalls only while the output queue holds a result
    `ASSERT_NEVER(a_stall_cause, in_stall && !out_valid, "input stalled with an empty output")

    // a stalled result stays valid with its byte and end flag unchanged
    `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(string_end), "stalled result changed")

endmodule

bind c_escape_unslash_stream_top ceus_chk #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
) u_ceus_chk (.*);
